// File: design/cts_pkg.sv
package cts_pkg;

	localparam int LexemeLimit  = 31;
	localparam int CounterWidth = 16;
	localparam int LenWidth     = $clog2(LexemeLimit + 1);
	localparam int HeadBytes    = 8;
	localparam int HeadWidth    = 8 * HeadBytes;
	localparam int ValueWidth   = 31;
	localparam int QueueDepth   = 4;
	localparam int QueuePtrWidth = $clog2(QueueDepth);

	localparam int IndexOutWidth = 16;
	localparam int LineOutWidth  = 16;
	localparam int LenOutWidth   = 5;
	localparam int TdataBits     = IndexOutWidth + LineOutWidth + LenOutWidth + HeadWidth
		+ ValueWidth + 2;
	localparam int TdataWidth    = ((TdataBits + 7) / 8) * 8;

	localparam int SlotWord = 0;
	localparam int SlotChar = 1;
	localparam int SlotEnd  = 2;
	localparam int SlotCount = 3;

	localparam logic [7:0] CH_NEWLINE = 8'h0a;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0d;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_SEMI    = 8'h3b;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_LBRACE  = 8'h7b;
	localparam logic [7:0] CH_RBRACE  = 8'h7d;
	localparam logic [7:0] CH_MINUS   = 8'h2d;
	localparam logic [7:0] CH_TILDE   = 8'h7e;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_UNDER   = 8'h5f;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_Z    = 8'h5a;
	localparam logic [7:0] CH_LO_A    = 8'h61;
	localparam logic [7:0] CH_LO_Z    = 8'h7a;

	localparam logic [HeadWidth-1:0] KW_INT    = 64'h0000_0000_0074_6e69;
	localparam logic [HeadWidth-1:0] KW_RETURN = 64'h0000_6e72_7574_6572;
	localparam logic [LenWidth-1:0]  KW_INT_LEN    = LenWidth'(3);
	localparam logic [LenWidth-1:0]  KW_RETURN_LEN = LenWidth'(6);

	typedef enum logic [3:0] {
		TK_INVALID = 4'd0,
		TK_IDENT   = 4'd1,
		TK_INT     = 4'd2,
		TK_LPAREN  = 4'd3,
		TK_RPAREN  = 4'd4,
		TK_LBRACE  = 4'd5,
		TK_RBRACE  = 4'd6,
		TK_RETURN  = 4'd7,
		TK_NUMBER  = 4'd8,
		TK_MINUS   = 4'd9,
		TK_TILDE   = 4'd10,
		TK_BANG    = 4'd11,
		TK_SEMI    = 4'd12,
		TK_END     = 4'd13
	} token_kind_t;

	typedef logic [CounterWidth-1:0] count_t;
	typedef logic [LenWidth-1:0]     len_t;

	typedef struct packed {
		token_kind_t           kind;
		count_t                index;
		count_t                line;
		len_t                  len;
		logic [HeadWidth-1:0]  head;
		logic [ValueWidth-1:0] value;
		logic                  ovf;
		logic                  trunc;
	} token_t;

	// slot 0 word, slot 1 single char, slot 2 end
	typedef struct packed {
		logic [SlotCount-1:0]   valid;
		token_t [SlotCount-1:0] tok;
	} job_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_word_byte(input logic [7:0] c);
		return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z))
			|| is_digit(c) || (c == CH_UNDER);
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
	endfunction

	function automatic token_kind_t punct_kind(input logic [7:0] c);
		token_kind_t k;
		unique case (c)
			CH_SEMI:   k = TK_SEMI;
			CH_LPAREN: k = TK_LPAREN;
			CH_RPAREN: k = TK_RPAREN;
			CH_LBRACE: k = TK_LBRACE;
			CH_RBRACE: k = TK_RBRACE;
			CH_MINUS:  k = TK_MINUS;
			CH_TILDE:  k = TK_TILDE;
			CH_BANG:   k = TK_BANG;
			default:   k = TK_INVALID;
		endcase
		return k;
	endfunction

	function automatic count_t sat_inc(input count_t c);
		return (&c) ? c : c + count_t'(1);
	endfunction

endpackage

// File: design/cts_front.sv
module cts_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     in_char,
	input  logic           in_last,
	input  logic           queue_full,
	output logic           push,
	output cts_pkg::job_t  job
);

	logic                                 after_q;
	cts_pkg::len_t                        len_q;
	logic [cts_pkg::HeadWidth-1:0]        head_q;
	logic                                 digits_q;
	logic [cts_pkg::ValueWidth-1:0]       acc_q;
	logic                                 ovf_q;
	logic                                 long_q;
	cts_pkg::count_t                      line_q;
	cts_pkg::count_t                      tok_q;

	logic                                 accept;
	logic                                 is_word;
	logic                                 is_dig;
	logic                                 is_nl;
	cts_pkg::len_t                        upd_len;
	logic                                 upd_long;
	logic [cts_pkg::HeadWidth-1:0]        upd_head;
	logic [cts_pkg::HeadWidth-1:0]        ins_head;
	logic                                 upd_digits;
	logic [cts_pkg::ValueWidth-1:0]       upd_acc;
	logic                                 upd_ovf;
	logic [cts_pkg::ValueWidth+3:0]       acc_ext;
	logic [cts_pkg::ValueWidth+3:0]       acc_next;

	cts_pkg::len_t                        ew_len;
	logic                                 ew_long;
	logic [cts_pkg::HeadWidth-1:0]        ew_head;
	logic                                 ew_digits;
	logic [cts_pkg::ValueWidth-1:0]       ew_acc;
	logic                                 ew_ovf;
	cts_pkg::token_kind_t                 word_kind;

	cts_pkg::count_t                      inc1;
	cts_pkg::count_t                      inc2;
	cts_pkg::count_t                      next_tok;
	logic [cts_pkg::SlotCount-1:0]        valid;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	assign is_word = cts_pkg::is_word_byte(in_char);
	assign is_dig  = cts_pkg::is_digit(in_char);
	assign is_nl   = (in_char == cts_pkg::CH_NEWLINE);

	// word state after taking in this byte
	assign upd_long = long_q || (len_q == cts_pkg::len_t'(cts_pkg::LexemeLimit));
	assign upd_len  = (len_q == cts_pkg::len_t'(cts_pkg::LexemeLimit)) ? len_q
		: len_q + cts_pkg::len_t'(1);
	assign ins_head = cts_pkg::HeadWidth'(in_char) << {len_q[2:0], 3'b000};
	assign upd_head = (len_q < cts_pkg::len_t'(cts_pkg::HeadBytes)) ? (head_q | ins_head)
		: head_q;

	assign acc_ext  = (cts_pkg::ValueWidth + 4)'(acc_q);
	assign acc_next = (acc_ext << 3) + (acc_ext << 1)
		+ (cts_pkg::ValueWidth + 4)'(in_char[3:0]);

	always_comb begin
		upd_digits = digits_q;
		upd_acc    = acc_q;
		upd_ovf    = ovf_q;
		if (is_dig) begin
			if (digits_q && !ovf_q) begin
				if (acc_next[cts_pkg::ValueWidth+3:cts_pkg::ValueWidth] != 4'd0) begin
					upd_ovf = 1'b1;
				end else begin
					upd_acc = acc_next[cts_pkg::ValueWidth-1:0];
				end
			end
		end else begin
			upd_digits = 1'b0;
		end
	end

	assign ew_len    = is_word ? upd_len    : len_q;
	assign ew_long   = is_word ? upd_long   : long_q;
	assign ew_head   = is_word ? upd_head   : head_q;
	assign ew_digits = is_word ? upd_digits : digits_q;
	assign ew_acc    = is_word ? upd_acc    : acc_q;
	assign ew_ovf    = is_word ? upd_ovf    : ovf_q;

	always_comb begin
		priority if (!ew_long && ew_len == cts_pkg::KW_INT_LEN && ew_head == cts_pkg::KW_INT) begin
			word_kind = cts_pkg::TK_INT;
		end else if (!ew_long && ew_len == cts_pkg::KW_RETURN_LEN
				&& ew_head == cts_pkg::KW_RETURN) begin
			word_kind = cts_pkg::TK_RETURN;
		end else if (ew_digits) begin
			word_kind = cts_pkg::TK_NUMBER;
		end else begin
			word_kind = cts_pkg::TK_IDENT;
		end
	end

	assign inc1 = cts_pkg::sat_inc(tok_q);
	assign inc2 = cts_pkg::sat_inc(inc1);

	assign valid[cts_pkg::SlotWord] = is_word ? in_last : after_q;
	assign valid[cts_pkg::SlotChar] = !is_word && !is_nl && !cts_pkg::is_blank(in_char);
	assign valid[cts_pkg::SlotEnd]  = in_last;

	always_comb begin
		unique case ({valid[cts_pkg::SlotWord], valid[cts_pkg::SlotChar]})
			2'b00:   next_tok = tok_q;
			2'b11:   next_tok = inc2;
			default: next_tok = inc1;
		endcase
	end

	always_comb begin
		job.valid = valid;

		job.tok[cts_pkg::SlotWord].kind  = word_kind;
		job.tok[cts_pkg::SlotWord].index = tok_q;
		job.tok[cts_pkg::SlotWord].line  = line_q;
		job.tok[cts_pkg::SlotWord].len   = ew_len;
		job.tok[cts_pkg::SlotWord].head  = ew_head;
		job.tok[cts_pkg::SlotWord].value = (word_kind == cts_pkg::TK_NUMBER && !ew_ovf)
			? ew_acc : '0;
		job.tok[cts_pkg::SlotWord].ovf   = (word_kind == cts_pkg::TK_NUMBER) && ew_ovf;
		job.tok[cts_pkg::SlotWord].trunc = ew_long;

		job.tok[cts_pkg::SlotChar].kind  = cts_pkg::punct_kind(in_char);
		job.tok[cts_pkg::SlotChar].index = valid[cts_pkg::SlotWord] ? inc1 : tok_q;
		job.tok[cts_pkg::SlotChar].line  = line_q;
		job.tok[cts_pkg::SlotChar].len   = cts_pkg::len_t'(1);
		job.tok[cts_pkg::SlotChar].head  = cts_pkg::HeadWidth'(in_char);
		job.tok[cts_pkg::SlotChar].value = '0;
		job.tok[cts_pkg::SlotChar].ovf   = 1'b0;
		job.tok[cts_pkg::SlotChar].trunc = 1'b0;

		job.tok[cts_pkg::SlotEnd].kind   = cts_pkg::TK_END;
		job.tok[cts_pkg::SlotEnd].index  = next_tok;
		job.tok[cts_pkg::SlotEnd].line   = (!is_word && is_nl) ? cts_pkg::sat_inc(line_q)
			: line_q;
		job.tok[cts_pkg::SlotEnd].len    = '0;
		job.tok[cts_pkg::SlotEnd].head   = '0;
		job.tok[cts_pkg::SlotEnd].value  = '0;
		job.tok[cts_pkg::SlotEnd].ovf    = 1'b0;
		job.tok[cts_pkg::SlotEnd].trunc  = 1'b0;
	end

	assign push = accept && (|valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_q  <= 1'b0;
			len_q    <= '0;
			head_q   <= '0;
			digits_q <= 1'b1;
			acc_q    <= '0;
			ovf_q    <= 1'b0;
			long_q   <= 1'b0;
			line_q   <= cts_pkg::count_t'(1);
			tok_q    <= '0;
		end else if (accept) begin
			if (in_last || !is_word) begin
				after_q  <= 1'b0;
				len_q    <= '0;
				head_q   <= '0;
				digits_q <= 1'b1;
				acc_q    <= '0;
				ovf_q    <= 1'b0;
				long_q   <= 1'b0;
			end else begin
				after_q  <= 1'b1;
				len_q    <= upd_len;
				head_q   <= upd_head;
				digits_q <= upd_digits;
				acc_q    <= upd_acc;
				ovf_q    <= upd_ovf;
				long_q   <= upd_long;
			end
			if (in_last) begin
				line_q <= cts_pkg::count_t'(1);
				tok_q  <= '0;
			end else begin
				if (!is_word && is_nl) begin
					line_q <= cts_pkg::sat_inc(line_q);
				end
				tok_q <= next_tok;
			end
		end
	end

	// word state is clean whenever no word is open
	a_clean_when_closed: assert property (@(posedge clk) disable iff (!arst_n)
		!after_q |-> (len_q == '0 && head_q == '0 && digits_q && !ovf_q && !long_q))
		else $error("word state not clear outside a word");

	a_restart_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_last |=> (tok_q == '0 && line_q == cts_pkg::count_t'(1) && !after_q))
		else $error("scanner did not restart after end of source");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0)
		else $error("line counter reached zero");

endmodule

// File: design/cts_queue.sv
module cts_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cts_pkg::job_t  wr_data,
	input  logic           pop,
	output cts_pkg::job_t  rd_data,
	output logic           empty,
	output logic           full
);

	cts_pkg::job_t                       mem_q [cts_pkg::QueueDepth];
	logic [cts_pkg::QueuePtrWidth-1:0]   wr_ptr_q;
	logic [cts_pkg::QueuePtrWidth-1:0]   rd_ptr_q;
	logic [cts_pkg::QueuePtrWidth:0]     count_q;
	logic                                do_push;
	logic                                do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == (cts_pkg::QueuePtrWidth + 1)'(cts_pkg::QueueDepth));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/cts_back.sv
module cts_back (
	input  logic             clk,
	input  logic             arst_n,
	input  cts_pkg::job_t    head_job,
	input  logic             queue_empty,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output cts_pkg::token_t  out_tok,
	output logic             out_last
);

	logic [cts_pkg::SlotCount-1:0]  done_q;
	logic                           valid_q;
	cts_pkg::token_t                tok_q;
	logic                           last_q;

	logic [cts_pkg::SlotCount-1:0]  pending;
	logic [cts_pkg::SlotCount-1:0]  sel;
	logic [1:0]                     sel_idx;
	logic                           sel_last;
	logic                           load;

	assign pending = head_job.valid & ~done_q;

	always_comb begin
		priority if (pending[cts_pkg::SlotWord]) begin
			sel_idx = 2'(cts_pkg::SlotWord);
		end else if (pending[cts_pkg::SlotChar]) begin
			sel_idx = 2'(cts_pkg::SlotChar);
		end else begin
			sel_idx = 2'(cts_pkg::SlotEnd);
		end
	end

	assign sel      = cts_pkg::SlotCount'(1) << sel_idx;
	assign sel_last = ((pending & ~sel) == '0);
	assign load     = !queue_empty && (!valid_q || out_ready);
	assign pop      = load && sel_last;

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q  <= head_job.tok[sel_idx];
			last_q <= sel_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			done_q  <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			if (pop) begin
				done_q <= '0;
			end else if (load) begin
				done_q <= done_q | sel;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_tok   = tok_q;
	assign out_last  = last_q;

	a_head_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		!queue_empty |-> (pending != '0))
		else $error("queue head has no token left");

	a_done_clear_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		queue_empty |-> (done_q == '0))
		else $error("progress mask set with empty queue");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q)
		else $error("loaded token not presented");

endmodule

// File: design/c_subset_token_scanner_unit.sv
// token scanner for a small c subset
// input stream: one source byte per beat, tdata[7:0] the byte, tlast marks the last byte
// of the source. output stream: one token per beat, tuser the token kind, tlast on the
// last token that one input byte produced.
// a byte may produce zero to three tokens: a closed word, a single-char token and, with
// tlast, the end token. the front stage classifies each byte and updates the word,
// number and counter registers in the cycle it is accepted, and queues a record of
// the tokens it causes; the back stage sends those tokens one per beat.
// throughput: one byte per cycle while each byte yields at most one token and the
// receiver takes every beat; output is one token per cycle unless stalled, so bytes
// with two or three tokens take that many output beats, absorbed by a four-record
// queue between the stages.
// when the receiver stalls the queue fills and s_axis_tready drops; nothing is lost.
// reset empties the queue and output register and starts at token 0, line 1; after an
// end token the scanner restarts the same way.
module c_subset_token_scanner_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,   // source_char
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// token_index, line_number, lexeme_length, lexeme_head, number_value,
	// number_overflow, lexeme_truncated, zero pad
	output logic [cts_pkg::TdataWidth-1:0] m_axis_tdata,
	output logic [3:0]                     m_axis_tuser,   // token_kind
	output logic                           m_axis_tlast
);

	cts_pkg::job_t    push_job;
	cts_pkg::job_t    head_job;
	logic             push;
	logic             pop;
	logic             queue_empty;
	logic             queue_full;
	cts_pkg::token_t  out_tok;
	logic [31:0]      index_wide;
	logic [31:0]      line_wide;
	logic [31:0]      len_wide;

	cts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_char    (s_axis_tdata),
		.in_last    (s_axis_tlast),
		.queue_full (queue_full),
		.push       (push),
		.job        (push_job)
	);

	cts_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_job),
		.pop     (pop),
		.rd_data (head_job),
		.empty   (queue_empty),
		.full    (queue_full)
	);

	cts_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_job    (head_job),
		.queue_empty (queue_empty),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_tok     (out_tok),
		.out_last    (m_axis_tlast)
	);

	assign index_wide = 32'(out_tok.index);
	assign line_wide  = 32'(out_tok.line);
	assign len_wide   = 32'(out_tok.len);

	assign m_axis_tuser = out_tok.kind;
	assign m_axis_tdata = cts_pkg::TdataWidth'({
		out_tok.trunc,
		out_tok.ovf,
		out_tok.value,
		out_tok.head,
		len_wide[cts_pkg::LenOutWidth-1:0],
		line_wide[cts_pkg::LineOutWidth-1:0],
		index_wide[cts_pkg::IndexOutWidth-1:0]
	});

endmodule

// File: tb/c_subset_token_scanner_unit_tb.sv
module c_subset_token_scanner_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0]  CR_CHAR     = 8'h0d;
	localparam logic [63:0] INT_WORD    = 64'h0000_0000_0074_6e69;
	localparam logic [63:0] RETURN_WORD = 64'h0000_6e72_7574_6572;
	localparam int          WORD_LIMIT  = 31;

	typedef struct packed {
		cts_pkg::token_kind_t  kind;
		logic [15:0]  index;
		logic [15:0]  line;
		logic [4:0]   len;
		logic [63:0]  head;
		logic [30:0]  value;
		logic         ovf;
		logic         trunc;
		logic         last;
	} scan_token_t;

	typedef struct packed {
		logic [7:0]   ch;
		logic         last;
		logic         typed;
		scan_token_t  want;
	} source_row_t;

	logic clk;
	logic arst_n;
	logic s_valid;
	logic s_ready;
	logic [7:0] s_data;
	logic s_last;
	logic m_valid;
	logic m_ready = 1'b0;
	logic [cts_pkg::TdataWidth-1:0] m_data;
	logic [3:0] m_user;
	logic m_last;

	bit no_idle;
	int mismatches;
	scan_token_t pending_tokens[$];
	source_row_t directed_rows[$];
	logic [7:0] src_bytes[$];

	// scanner state mirrored by the predictor
	logic in_word;
	logic [4:0] word_len;
	logic [63:0] word_bytes;
	logic digits_only;
	logic [30:0] num_acc;
	logic num_ovf;
	logic word_long;
	logic [15:0] cur_line;
	logic [15:0] tok_count;

	c_subset_token_scanner_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.s_axis_tlast  (s_last),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data),
		.m_axis_tuser  (m_user),
		.m_axis_tlast  (m_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic word_byte(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9")
			|| c == "_";
	endfunction

	function automatic void clear_word();
		in_word = 1'b0;
		word_len = '0;
		word_bytes = '0;
		digits_only = 1'b1;
		num_acc = '0;
		num_ovf = 1'b0;
		word_long = 1'b0;
	endfunction

	function automatic void reset_scanner();
		clear_word();
		cur_line = 16'd1;
		tok_count = '0;
	endfunction

	function automatic void add_token(input cts_pkg::token_kind_t k, input logic [4:0] len,
			input logic [63:0] head, input logic [30:0] val, input logic ovf,
			input logic trunc);
		scan_token_t t;
		t.kind = k;
		t.index = tok_count;
		t.line = cur_line;
		t.len = len;
		t.head = head;
		t.value = val;
		t.ovf = ovf;
		t.trunc = trunc;
		t.last = 1'b0;
		pending_tokens.push_back(t);
		if (tok_count != '1)
			tok_count++;
	endfunction

	function automatic void close_word();
		cts_pkg::token_kind_t k;
		logic [30:0] val;
		logic ovf;
		k = cts_pkg::TK_IDENT;
		val = '0;
		ovf = 1'b0;
		if (!word_long && word_len == 5'd3 && word_bytes == INT_WORD)
			k = cts_pkg::TK_INT;
		else if (!word_long && word_len == 5'd6 && word_bytes == RETURN_WORD)
			k = cts_pkg::TK_RETURN;
		else if (digits_only) begin
			k = cts_pkg::TK_NUMBER;
			ovf = num_ovf;
			val = num_ovf ? '0 : num_acc;
		end
		add_token(k, word_len, word_bytes, val, ovf, word_long);
		clear_word();
	endfunction

	function automatic void scan_byte(input logic [7:0] c, input logic last);
		int first;
		longint v;
		cts_pkg::token_kind_t k;
		first = pending_tokens.size();
		if (word_byte(c)) begin
			if (!in_word)
				clear_word();
			if (word_len < WORD_LIMIT) begin
				if (word_len < 8)
					word_bytes[8 * word_len +: 8] = c;
				word_len++;
			end else begin
				word_long = 1'b1;
			end
			if (c >= "0" && c <= "9") begin
				if (digits_only && !num_ovf) begin
					v = longint'(num_acc) * 10 + longint'(c - 8'h30);
					if (v > 64'h7fff_ffff)
						num_ovf = 1'b1;
					else
						num_acc = v[30:0];
				end
			end else begin
				digits_only = 1'b0;
			end
			in_word = 1'b1;
		end else begin
			if (in_word)
				close_word();
			if (c == "\n") begin
				if (cur_line != '1)
					cur_line++;
			end else if (c != " " && c != "\t" && c != CR_CHAR) begin
				case (c)
					";": k = cts_pkg::TK_SEMI;
					"(": k = cts_pkg::TK_LPAREN;
					")": k = cts_pkg::TK_RPAREN;
					"{": k = cts_pkg::TK_LBRACE;
					"}": k = cts_pkg::TK_RBRACE;
					"-": k = cts_pkg::TK_MINUS;
					"~": k = cts_pkg::TK_TILDE;
					"!": k = cts_pkg::TK_BANG;
					default: k = cts_pkg::TK_INVALID;
				endcase
				add_token(k, 5'd1, {56'd0, c}, '0, 1'b0, 1'b0);
			end
		end
		if (last) begin
			if (in_word)
				close_word();
			add_token(cts_pkg::TK_END, '0, '0, '0, 1'b0, 1'b0);
			reset_scanner();
		end
		if (pending_tokens.size() > first)
			pending_tokens[pending_tokens.size() - 1].last = 1'b1;
	endfunction

	function automatic scan_token_t typed_tok(input cts_pkg::token_kind_t k, input int idx,
			input int ln, input int len, input logic [63:0] head);
		scan_token_t t;
		t = '0;
		t.kind = k;
		t.index = idx[15:0];
		t.line = ln[15:0];
		t.len = len[4:0];
		t.head = head;
		t.last = 1'b1;
		return t;
	endfunction

	function automatic void row(input logic [7:0] ch, input logic last, input logic typed,
			input scan_token_t want);
		source_row_t r;
		r.ch = ch;
		r.last = last;
		r.typed = typed;
		r.want = want;
		directed_rows.push_back(r);
	endfunction

	function automatic logic [7:0] word_char(input logic lead);
		int i;
		i = lead ? $urandom_range(52) : $urandom_range(62);
		if (i < 26)
			return 8'("a" + i);
		else if (i < 52)
			return 8'("A" + i - 26);
		else if (i == 52)
			return "_";
		return 8'("0" + i - 53);
	endfunction

	function automatic logic [7:0] gap_char();
		string gaps;
		int i;
		gaps = " \t\n();{}-~!";
		i = $urandom_range(gaps.len());
		if (i == gaps.len())
			return CR_CHAR;
		return gaps[i];
	endfunction

	function automatic void build_source();
		int goal;
		int len;
		int r;
		int i;
		string txt;
		src_bytes.delete();
		goal = $urandom_range(60, 8);
		while (src_bytes.size() < goal) begin
			r = $urandom_range(99);
			if (r < 60) begin
				if (r < 15) begin
					if ($urandom_range(1))
						txt = "int";
					else
						txt = "return";
					for (i = 0; i < txt.len(); i++)
						src_bytes.push_back(txt[i]);
					if ($urandom_range(3) == 0)
						src_bytes.push_back(word_char(1'b0));
				end else if (r < 38) begin
					len = ($urandom_range(9) == 0) ? $urandom_range(40, 30) : $urandom_range(9, 1);
					src_bytes.push_back(word_char(1'b1));
					for (i = 1; i < len; i++)
						src_bytes.push_back(word_char(1'b0));
				end else begin
					r = $urandom_range(99);
					if (r < 10)
						txt = "2147483647";
					else if (r < 20)
						txt = "2147483648";
					else
						txt = "";
					if (txt.len() == 0) begin
						if (r < 30)
							len = $urandom_range(14, 11);
						else if (r < 35)
							len = $urandom_range(36, 32);
						else
							len = $urandom_range(9, 1);
						for (i = 0; i < len; i++)
							src_bytes.push_back(8'("0" + $urandom_range(9)));
					end else begin
						for (i = 0; i < txt.len(); i++)
							src_bytes.push_back(txt[i]);
					end
				end
				if ($urandom_range(99) < 85)
					src_bytes.push_back(gap_char());
			end else if (r < 90) begin
				src_bytes.push_back(gap_char());
			end else begin
				src_bytes.push_back(8'($urandom_range(255)));
			end
		end
		r = $urandom_range(2);
		if (r == 0)
			src_bytes.push_back(8'($urandom_range(255)));
		else if (r == 1)
			src_bytes.push_back(gap_char());
		else
			src_bytes.push_back(word_char(1'b0));
	endfunction

	task automatic send_byte(input logic [7:0] c, input logic last, input logic typed,
			input scan_token_t want);
		@(negedge clk);
		if (!no_idle) begin
			while ($urandom_range(99) < 15) begin
				s_valid <= 1'b0;
				@(negedge clk);
			end
		end
		s_valid <= 1'b1;
		s_data <= c;
		s_last <= last;
		do
			@(posedge clk);
		while (!s_ready);
		scan_byte(c, last);
		if (typed)
			pending_tokens[pending_tokens.size() - 1] = want;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_valid <= 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);
	endtask

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$error("%s: expected %0h, got %0h", name, want, got);
		end
	endfunction

	always @(negedge clk)
		m_ready <= no_idle || ($urandom_range(99) >= 15);

	always @(posedge clk) begin : token_check
		scan_token_t want;
		if (arst_n && m_valid && m_ready) begin
			if (pending_tokens.size() == 0) begin
				mismatches++;
				$error("token beat with nothing expected, kind %0d", m_user);
			end else begin
				want = pending_tokens.pop_front();
				check_field("token_kind", want.kind, m_user);
				check_field("token_index", want.index, m_data[15:0]);
				check_field("line_number", want.line, m_data[31:16]);
				check_field("lexeme_length", want.len, m_data[36:32]);
				check_field("lexeme_head", want.head, m_data[100:37]);
				check_field("number_value", want.value, m_data[131:101]);
				check_field("number_overflow", want.ovf, m_data[132]);
				check_field("lexeme_truncated", want.trunc, m_data[133]);
				check_field("last_of_run", want.last, m_last);
			end
		end
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int n;
		int src_count;
		int sent;
		arst_n = 1'b0;
		s_valid = 1'b0;
		s_data = '0;
		s_last = 1'b0;
		no_idle = 1'b0;
		mismatches = 0;
		reset_scanner();

		row(";",     1'b0, 1'b1, typed_tok(cts_pkg::TK_SEMI, 0, 1, 1, 64'h3b));
		row(8'hff,   1'b0, 1'b1, typed_tok(cts_pkg::TK_INVALID, 1, 1, 1, 64'hff));
		row(8'h00,   1'b0, 1'b1, typed_tok(cts_pkg::TK_INVALID, 2, 1, 1, 64'h00));
		row(8'h80,   1'b0, 1'b0, '0);
		row("\n",    1'b0, 1'b0, '0);
		row("i",     1'b0, 1'b0, '0);
		row("n",     1'b0, 1'b0, '0);
		row("t",     1'b0, 1'b0, '0);
		row("(",     1'b0, 1'b0, '0);
		row(")",     1'b0, 1'b0, '0);
		row("{",     1'b0, 1'b0, '0);
		row("}",     1'b0, 1'b0, '0);
		row("-",     1'b0, 1'b0, '0);
		row("~",     1'b0, 1'b0, '0);
		row("!",     1'b0, 1'b0, '0);
		row("\t",    1'b0, 1'b0, '0);
		row(CR_CHAR, 1'b0, 1'b0, '0);
		row("r",     1'b0, 1'b0, '0);
		row("e",     1'b0, 1'b0, '0);
		row("t",     1'b0, 1'b0, '0);
		row("u",     1'b0, 1'b0, '0);
		row("r",     1'b0, 1'b0, '0);
		row("n",     1'b0, 1'b0, '0);
		row(" ",     1'b0, 1'b0, '0);
		row("7",     1'b0, 1'b0, '0);
		row(";",     1'b0, 1'b0, '0);
		row("Z",     1'b1, 1'b0, '0);
		// scanner restarts after the end token
		row(" ",     1'b1, 1'b1, typed_tok(cts_pkg::TK_END, 0, 1, 0, 64'h0));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_byte(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].typed,
				directed_rows[i].want);
		wait_drained();

		src_count = 0;
		sent = directed_rows.size();
		while (sent < 450) begin
			// long stretch without any idling on either side
			no_idle = (src_count >= 3 && src_count < 7);
			build_source();
			foreach (src_bytes[i])
				send_byte(src_bytes[i], i == src_bytes.size() - 1, 1'b0, '0);
			sent += src_bytes.size();
			src_count++;
		end
		no_idle = 1'b0;

		@(negedge clk);
		s_valid <= 1'b0;
		for (n = 0; n < 5000 && pending_tokens.size() != 0; n++)
			@(posedge clk);
		if (pending_tokens.size() != 0) begin
			mismatches++;
			$error("%0d expected tokens never arrived", pending_tokens.size());
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
